// ----- rtl/tcpopt_pkg.sv -----
package tcpopt_pkg;

   localparam int REGION_MAX_BYTES = 40;
   localparam int POS_W = $clog2(REGION_MAX_BYTES + 1);

   typedef enum logic [1:0] {
      PH_KIND = 2'd0,
      PH_LEN  = 2'd1,
      PH_DATA = 2'd2,
      PH_DONE = 2'd3
   } phase_type;

   localparam logic [7:0] KIND_EOL    = 8'd0;
   localparam logic [7:0] KIND_NOP    = 8'd1;
   localparam logic [7:0] KIND_MSS    = 8'd2;
   localparam logic [7:0] KIND_WSCALE = 8'd3;
   localparam logic [7:0] KIND_SACK   = 8'd5;
   localparam logic [7:0] KIND_STAMP  = 8'd8;

   localparam logic [7:0] LEN_MIN     = 8'd2;
   localparam logic [7:0] WSCALE_MAX  = 8'd14;
   localparam logic [5:0] DATA_BYTES  = 6'd8;

endpackage

// ----- rtl/tcp_option_parser_unit.sv -----
// Output: the result of an accepted byte, when it has one, is registered onto rsp_.
// Throughput: one option byte per cycle; req_ready drops only while a held
// result is not taken.
// Reset: synchronous, active high; the walk is armed at position 0 and no
// result is held.
module tcp_option_parser_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_opt_byte,
   input  logic         req_region_first,
   input  logic         req_region_last,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_opt_complete,
   output logic         rsp_sack_valid,
   output logic         rsp_walk_end,
   output logic         rsp_bad_length,
   output logic [7:0]   rsp_option_kind,
   output logic [5:0]   rsp_option_length,
   output logic [15:0]  rsp_short_value,
   output logic [31:0]  rsp_stamp_value,
   output logic [31:0]  rsp_stamp_echo,
   output logic [1:0]   rsp_block_index,
   output logic [31:0]  rsp_block_left,
   output logic [31:0]  rsp_block_right
);

   localparam int PW = tcpopt_pkg::POS_W;

   tcpopt_pkg::phase_type phase_ff, phase_in, eff_phase;
   logic [7:0]  kind_ff, kind_in, eff_kind;
   logic [7:0]  len_ff, len_in, eff_len;
   logic [5:0]  bio_ff, bio_in, eff_bio;
   logic [63:0] shift_ff, shift_in, eff_shift;
   logic [1:0]  sackcnt_ff, sackcnt_in, eff_sackcnt;
   logic [PW-1:0] pos_ff, pos_in, eff_pos;

   logic        accept;
   logic        active, last, is_single, room_bad, len_reached, is_sack_kind;
   logic [8:0]  room;
   logic [5:0]  bio_inc, d;
   logic [2:0]  lane;
   logic [63:0] shift_base, shift_data, shift_src;
   logic [7:0]  kind_src, len_src;

   logic        done, sack, wend, bad, has_result;
   logic [7:0]  kind_o;
   logic [5:0]  len_o;
   logic [15:0] short_o;
   logic [31:0] tsv_o, tse_o, bl_o, br_o;
   logic [1:0]  bidx_o;

   logic         rsp_valid_ff;
   logic         done_ff, sack_ff, wend_ff, bad_ff;
   logic [7:0]   kind_o_ff;
   logic [5:0]   len_o_ff;
   logic [15:0]  short_ff;
   logic [31:0]  tsv_ff, tse_ff, bl_ff, br_ff;
   logic [1:0]   bidx_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // a first word restarts the walk before it is parsed
   always_comb begin
      if (req_region_first) begin
         eff_phase   = tcpopt_pkg::PH_KIND;
         eff_kind    = '0;
         eff_len     = '0;
         eff_bio     = '0;
         eff_shift   = '0;
         eff_sackcnt = '0;
         eff_pos     = '0;
      end else begin
         eff_phase   = phase_ff;
         eff_kind    = kind_ff;
         eff_len     = len_ff;
         eff_bio     = bio_ff;
         eff_shift   = shift_ff;
         eff_sackcnt = sackcnt_ff;
         eff_pos     = pos_ff;
      end
   end

   always_comb begin
      active       = (eff_phase != tcpopt_pkg::PH_DONE);
      last         = req_region_last ||
                     (eff_pos >= PW'(tcpopt_pkg::REGION_MAX_BYTES - 1));
      is_single    = (req_opt_byte == tcpopt_pkg::KIND_EOL) ||
                     (req_opt_byte == tcpopt_pkg::KIND_NOP);
      room         = 9'(tcpopt_pkg::REGION_MAX_BYTES + 1) - 9'(eff_pos);
      room_bad     = (req_opt_byte < tcpopt_pkg::LEN_MIN) || ({1'b0, req_opt_byte} > room);
      bio_inc      = eff_bio + 6'd1;
      len_reached  = ({2'b00, bio_inc} >= eff_len);
      is_sack_kind = (eff_kind == tcpopt_pkg::KIND_SACK);
      d            = eff_bio - 6'd2;
      lane         = d[2:0];
      shift_base   = (is_sack_kind && lane == 3'd0) ? 64'd0 : eff_shift;
      shift_data   = shift_base;
      if (is_sack_kind || d < tcpopt_pkg::DATA_BYTES) begin
         shift_data[{~lane, 3'b000} +: 8] = shift_base[{~lane, 3'b000} +: 8] | req_opt_byte;
      end
      shift_src    = (eff_phase == tcpopt_pkg::PH_DATA) ? shift_data : eff_shift;
      kind_src     = eff_kind;
      len_src      = (eff_phase == tcpopt_pkg::PH_LEN) ? req_opt_byte : eff_len;
   end

   // next state
   always_comb begin
      phase_in   = eff_phase;
      kind_in    = eff_kind;
      len_in     = eff_len;
      bio_in     = eff_bio;
      shift_in   = eff_shift;
      sackcnt_in = eff_sackcnt;
      pos_in     = eff_pos;
      if (active) begin
         if (eff_pos < PW'(tcpopt_pkg::REGION_MAX_BYTES)) begin
            pos_in = eff_pos + PW'(1);
         end
      end
      case (eff_phase)
         tcpopt_pkg::PH_KIND: begin
            if (is_single) begin
               if (req_opt_byte == tcpopt_pkg::KIND_EOL || last) begin
                  phase_in = tcpopt_pkg::PH_DONE;
               end
            end else if (last) begin
               phase_in = tcpopt_pkg::PH_DONE;
            end else begin
               kind_in    = req_opt_byte;
               len_in     = '0;
               bio_in     = 6'd1;
               shift_in   = '0;
               sackcnt_in = '0;
               phase_in   = tcpopt_pkg::PH_LEN;
            end
         end
         tcpopt_pkg::PH_LEN: begin
            bio_in = 6'd2;
            if (room_bad) begin
               phase_in = tcpopt_pkg::PH_DONE;
            end else begin
               len_in = req_opt_byte;
               if (last) begin
                  phase_in = tcpopt_pkg::PH_DONE;
               end else if (req_opt_byte == tcpopt_pkg::LEN_MIN) begin
                  phase_in = tcpopt_pkg::PH_KIND;
               end else begin
                  phase_in = tcpopt_pkg::PH_DATA;
               end
            end
         end
         tcpopt_pkg::PH_DATA: begin
            shift_in = shift_data;
            bio_in   = bio_inc;
            if (is_sack_kind && lane == 3'd7) begin
               sackcnt_in = eff_sackcnt + 2'd1;
            end
            if (last) begin
               phase_in = tcpopt_pkg::PH_DONE;
            end else if (len_reached) begin
               phase_in = tcpopt_pkg::PH_KIND;
            end
         end
         default: begin
            phase_in = eff_phase;
         end
      endcase
   end

   // result word
   always_comb begin
      done    = 1'b0;
      sack    = 1'b0;
      wend    = 1'b0;
      bad     = 1'b0;
      kind_o  = '0;
      len_o   = '0;
      short_o = '0;
      tsv_o   = '0;
      tse_o   = '0;
      bidx_o  = '0;
      bl_o    = '0;
      br_o    = '0;
      case (eff_phase)
         tcpopt_pkg::PH_KIND: begin
            if (is_single) begin
               done   = 1'b1;
               kind_o = req_opt_byte;
               len_o  = 6'd1;
               wend   = (req_opt_byte == tcpopt_pkg::KIND_EOL) || last;
            end else begin
               bad  = last;
               wend = last;
            end
         end
         tcpopt_pkg::PH_LEN: begin
            done = !room_bad && (req_opt_byte == tcpopt_pkg::LEN_MIN);
            bad  = room_bad || (req_opt_byte != tcpopt_pkg::LEN_MIN && last);
            wend = bad || (done && last);
         end
         tcpopt_pkg::PH_DATA: begin
            sack = is_sack_kind && (lane == 3'd7);
            done = len_reached;
            bad  = !len_reached && last;
            wend = bad || (done && last);
            if (sack) begin
               bidx_o = eff_sackcnt;
               bl_o   = shift_data[63:32];
               br_o   = shift_data[31:0];
            end
         end
         default: begin
            done = 1'b0;
         end
      endcase
      if (eff_phase != tcpopt_pkg::PH_KIND && done) begin
         kind_o = kind_src;
         len_o  = len_src[5:0];
         if (kind_src == tcpopt_pkg::KIND_MSS) begin
            short_o = shift_src[63:48];
         end else if (kind_src == tcpopt_pkg::KIND_WSCALE) begin
            short_o = (shift_src[63:56] > tcpopt_pkg::WSCALE_MAX) ?
                      {8'd0, tcpopt_pkg::WSCALE_MAX} : {8'd0, shift_src[63:56]};
         end else if (kind_src == tcpopt_pkg::KIND_STAMP) begin
            tsv_o = shift_src[63:32];
            tse_o = shift_src[31:0];
         end
      end
      has_result = active && (done || sack || wend || bad);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= tcpopt_pkg::PH_KIND;
         kind_ff      <= '0;
         len_ff       <= '0;
         bio_ff       <= '0;
         shift_ff     <= '0;
         sackcnt_ff   <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            kind_ff      <= kind_in;
            len_ff       <= len_in;
            bio_ff       <= bio_in;
            shift_ff     <= shift_in;
            sackcnt_ff   <= sackcnt_in;
            pos_ff       <= pos_in;
            rsp_valid_ff <= has_result;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && has_result) begin
         done_ff   <= done;
         sack_ff   <= sack;
         wend_ff   <= wend;
         bad_ff    <= bad;
         kind_o_ff <= kind_o;
         len_o_ff  <= len_o;
         short_ff  <= short_o;
         tsv_ff    <= tsv_o;
         tse_ff    <= tse_o;
         bidx_ff   <= bidx_o;
         bl_ff     <= bl_o;
         br_ff     <= br_o;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_opt_complete  = done_ff;
   assign rsp_sack_valid    = sack_ff;
   assign rsp_walk_end      = wend_ff;
   assign rsp_bad_length    = bad_ff;
   assign rsp_option_kind   = kind_o_ff;
   assign rsp_option_length = len_o_ff;
   assign rsp_short_value   = short_ff;
   assign rsp_stamp_value   = tsv_ff;
   assign rsp_stamp_echo    = tse_ff;
   assign rsp_block_index   = bidx_ff;
   assign rsp_block_left    = bl_ff;
   assign rsp_block_right   = br_ff;

endmodule
